// ===== rtl/sorted_unique_insert_table_unit_assert.svh =====
// Assertion shorthands used by the table unit RTL.
`ifndef SORTED_UNIQUE_INSERT_TABLE_UNIT_ASSERT_SVH
`define SORTED_UNIQUE_INSERT_TABLE_UNIT_ASSERT_SVH

// same-cycle implication
`define SUI_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define SUI_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/sui_pkg.sv =====
`timescale 1ns / 1ps
package sui_pkg;

   localparam int CAPACITY = 16;
   localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W    = $clog2(CAPACITY + 1);

   localparam int CMD_W    = 2;
   localparam int VAL_W    = 32;
   localparam int STAT_W   = 3;
   localparam int POS_W    = 6;
   localparam int ECNT_W   = 7;

   localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
   localparam logic [CMD_W-1:0] CMD_READ   = 2'd1;
   localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd2;

   localparam logic [STAT_W-1:0] ST_INSERTED  = 3'd0;
   localparam logic [STAT_W-1:0] ST_DUPLICATE = 3'd1;
   localparam logic [STAT_W-1:0] ST_FULL      = 3'd2;
   localparam logic [STAT_W-1:0] ST_ENTRY     = 3'd3;
   localparam logic [STAT_W-1:0] ST_EMPTY     = 3'd4;
   localparam logic [STAT_W-1:0] ST_CLEARED   = 3'd5;

   // broadcast from control to every cell
   typedef struct packed {
      logic                    ins_en;
      logic                    rot_en;
      logic signed [VAL_W-1:0] ins_value;
      logic [CNT_W-1:0]        count;
   } cell_ctl_type;

endpackage

// ===== rtl/sui_req_if.sv =====
`timescale 1ns / 1ps
interface sui_req_if;
   import sui_pkg::*;

   logic                    valid;
   logic                    ready;
   logic [CMD_W-1:0]        cmd;
   logic signed [VAL_W-1:0] value;

   modport source (output valid, cmd, value, input ready);
   modport sink   (input valid, cmd, value, output ready);
endinterface

// ===== rtl/sui_rsp_if.sv =====
`timescale 1ns / 1ps
interface sui_rsp_if;
   import sui_pkg::*;

   logic                    valid;
   logic                    ready;
   logic [STAT_W-1:0]       status;
   logic [POS_W-1:0]        position;
   logic signed [VAL_W-1:0] entry_value;
   logic [ECNT_W-1:0]       entry_count;
   logic                    last;

   modport source (output valid, status, position, entry_value, entry_count, last,
                   input ready);
   modport sink   (input valid, status, position, entry_value, entry_count, last,
                   output ready);
endinterface

// ===== rtl/sui_cell.sv =====
`timescale 1ns / 1ps
module sui_cell (
   input  logic                             clock,
   input  sui_pkg::cell_ctl_type            ctl,
   input  logic [sui_pkg::IDX_W-1:0]        my_index,
   input  logic                             left_lt,
   input  logic signed [sui_pkg::VAL_W-1:0] left_entry,
   input  logic signed [sui_pkg::VAL_W-1:0] right_entry,
   input  logic signed [sui_pkg::VAL_W-1:0] wrap_entry,
   output logic                             lt,
   output logic                             eq,
   output logic signed [sui_pkg::VAL_W-1:0] entry
);
   import sui_pkg::*;

   logic signed [VAL_W-1:0] entry_ff;
   logic signed [VAL_W-1:0] entry_in;
   logic [CNT_W-1:0]        idx_ext;
   logic                    occupied;
   logic                    is_tail;

   assign idx_ext  = CNT_W'(my_index);
   assign occupied = idx_ext < ctl.count;
   assign is_tail  = (idx_ext + CNT_W'(1)) == ctl.count;

   assign lt    = occupied && (entry_ff < ctl.ins_value);
   assign eq    = occupied && (entry_ff == ctl.ins_value);
   assign entry = entry_ff;

   always_comb begin
      entry_in = entry_ff;
      if (ctl.ins_en) begin
         // below the slot: keep; at the slot: new value; above: shift up
         if (!lt) begin
            if (my_index == '0 || left_lt) begin
               entry_in = ctl.ins_value;
            end else begin
               entry_in = left_entry;
            end
         end
      end else if (ctl.rot_en) begin
         entry_in = is_tail ? wrap_entry : right_entry;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

endmodule

// ===== rtl/sorted_unique_insert_table_unit.sv =====
`timescale 1ns / 1ps
// Sorted unique table: holds up to CAPACITY signed 32-bit values in strictly
// ascending order in a row of compare-and-shift cells. Insert (cmd 0) places the
// value at its sorted slot: every cell compares against the broadcast value, the
// cell at the slot takes it and cells above it take their lower neighbor's
// entry. A duplicate is rejected (status 1) even if the table is full; otherwise
// a full table rejects with status 2. Clear (cmd 2) and insert each give one
// item, and req.ready comes back the next cycle if rsp takes the item then;
// code 3 is swallowed with no item out. Read-all (cmd 1) streams the entries in
// order through cell 0 while the row rotates down one place per item, and holds
// req off until the last entry has been registered, longer if rsp stalls; an
// empty table gives a single status 4 item. After a read the row is back in its
// original order. Every rsp item carries last; a finished item waits in the
// output register, and the next request is taken only in a cycle where that
// register is empty or drains.
module sorted_unique_insert_table_unit (
   input  logic       clock,
   input  logic       reset,
   sui_req_if.sink    req,
   sui_rsp_if.source  rsp
);
   import sui_pkg::*;

   `include "sorted_unique_insert_table_unit_assert.svh"

   typedef enum logic {
      S_IDLE,
      S_READ
   } state_type;

   state_type               state_ff;
   logic [CNT_W-1:0]        count_ff;
   logic [IDX_W-1:0]        rd_idx_ff;

   logic                    rsp_valid_ff;
   logic [STAT_W-1:0]       status_ff;
   logic [POS_W-1:0]        position_ff;
   logic signed [VAL_W-1:0] value_ff;
   logic [ECNT_W-1:0]       ecount_ff;
   logic                    last_ff;

   // cell row
   cell_ctl_type            ctl;
   logic [CAPACITY-1:0]     lt_vec;
   logic [CAPACITY-1:0]     eq_vec;
   logic signed [VAL_W-1:0] entries [CAPACITY];

   logic                    out_free;
   logic                    accept;
   logic                    dup;
   logic                    full;
   logic [CNT_W-1:0]        ins_pos;
   logic                    rd_last;

   assign out_free = !rsp_valid_ff || rsp.ready;
   assign req.ready = (state_ff == S_IDLE) && out_free;
   assign accept   = req.valid && req.ready;

   assign dup     = |eq_vec;
   assign full    = count_ff == CNT_W'(CAPACITY);
   // compare flags form a thermometer, so their count is the slot
   assign ins_pos = CNT_W'($countones(lt_vec));
   assign rd_last = (CNT_W'(rd_idx_ff) + CNT_W'(1)) == count_ff;

   always_comb begin
      ctl.ins_en    = accept && (req.cmd == CMD_INSERT) && !dup && !full;
      ctl.rot_en    = (state_ff == S_READ) && out_free;
      ctl.ins_value = req.value;
      ctl.count     = count_ff;
   end

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic                    left_lt;
      logic signed [VAL_W-1:0] left_entry;
      logic signed [VAL_W-1:0] right_entry;

      if (i == 0) begin : g_head
         assign left_lt    = 1'b0;
         assign left_entry = entries[0];
      end else begin : g_body
         assign left_lt    = lt_vec[i-1];
         assign left_entry = entries[i-1];
      end

      if (i == CAPACITY - 1) begin : g_end
         assign right_entry = entries[0];
      end else begin : g_mid
         assign right_entry = entries[i+1];
      end

      sui_cell u_cell (
         .clock       (clock),
         .ctl         (ctl),
         .my_index    (IDX_W'(i)),
         .left_lt     (left_lt),
         .left_entry  (left_entry),
         .right_entry (right_entry),
         .wrap_entry  (entries[0]),
         .lt          (lt_vec[i]),
         .eq          (eq_vec[i]),
         .entry       (entries[i])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rd_idx_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (out_free) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  case (req.cmd)
                     CMD_INSERT: begin
                        rsp_valid_ff <= 1'b1;
                        value_ff     <= req.value;
                        last_ff      <= 1'b1;
                        if (dup) begin
                           status_ff   <= ST_DUPLICATE;
                           position_ff <= POS_W'(ins_pos);
                           ecount_ff   <= ECNT_W'(count_ff);
                        end else if (full) begin
                           status_ff   <= ST_FULL;
                           position_ff <= '0;
                           ecount_ff   <= ECNT_W'(count_ff);
                        end else begin
                           status_ff   <= ST_INSERTED;
                           position_ff <= POS_W'(ins_pos);
                           ecount_ff   <= ECNT_W'(count_ff) + ECNT_W'(1);
                           count_ff    <= count_ff + CNT_W'(1);
                        end
                     end
                     CMD_READ: begin
                        if (count_ff == '0) begin
                           rsp_valid_ff <= 1'b1;
                           status_ff    <= ST_EMPTY;
                           position_ff  <= '0;
                           value_ff     <= '0;
                           ecount_ff    <= '0;
                           last_ff      <= 1'b1;
                        end else begin
                           state_ff  <= S_READ;
                           rd_idx_ff <= '0;
                        end
                     end
                     CMD_CLEAR: begin
                        count_ff     <= '0;
                        rsp_valid_ff <= 1'b1;
                        status_ff    <= ST_CLEARED;
                        position_ff  <= '0;
                        value_ff     <= '0;
                        ecount_ff    <= '0;
                        last_ff      <= 1'b1;
                     end
                     default: begin
                        // unused code: dropped
                     end
                  endcase
               end
            end
            S_READ: begin
               // cell 0 always holds the next entry in order
               if (out_free) begin
                  rsp_valid_ff <= 1'b1;
                  status_ff    <= ST_ENTRY;
                  position_ff  <= POS_W'(rd_idx_ff);
                  value_ff     <= entries[0];
                  ecount_ff    <= ECNT_W'(count_ff);
                  last_ff      <= rd_last;
                  rd_idx_ff    <= rd_idx_ff + IDX_W'(1);
                  if (rd_last) begin
                     state_ff <= S_IDLE;
                  end
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.status      = status_ff;
   assign rsp.position    = position_ff;
   assign rsp.entry_value = value_ff;
   assign rsp.entry_count = ecount_ff;
   assign rsp.last        = last_ff;

   `SUI_ASSERT_NOW(a_count_bound, 1'b1, count_ff <= CNT_W'(CAPACITY),
      "entry count above capacity")
   `SUI_ASSERT_NOW(a_sorted_head, ctl.ins_en, !(lt_vec[0] == 1'b0 && lt_vec[1] == 1'b1),
      "compare flags not a thermometer")
   `SUI_ASSERT_NEXT(a_clear_empties, accept && req.cmd == CMD_CLEAR, count_ff == '0,
      "clear left entries behind")
   `SUI_ASSERT_NOW(a_read_last_pos,
      rsp_valid_ff && status_ff == ST_ENTRY && last_ff,
      ECNT_W'(position_ff) + ECNT_W'(1) == ecount_ff,
      "final read item not at the top entry")
   `SUI_ASSERT_NOW(a_no_insert_in_read, state_ff == S_READ, !ctl.ins_en,
      "insert during read-out")

endmodule
